/* rtl/csvdcp_pkg.sv */
// Shared types and constants of the drive command line parser.
package csvdcp_pkg;

   // ASCII bytes the parser reacts to
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // class of a kept byte, as queued between front and back
   localparam logic [1:0] KIND_DIGIT = 2'd0;
   localparam logic [1:0] KIND_MINUS = 2'd1;
   localparam logic [1:0] KIND_COMMA = 2'd2;
   localparam logic [1:0] KIND_EOL   = 2'd3;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_W    = 2;
   localparam int QUEUE_CNT_W    = 3;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 24;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] digit;
      logic       nonempty;   // EOL only: line held kept bytes
   } entry_type;

   // first member sits in the highest bits, so left_update lands at bit 0
   typedef struct packed {
      logic [1:0]        signal_command;
      logic              signal_update;
      logic signed [7:0] right_speed;
      logic              right_update;
      logic signed [7:0] left_speed;
      logic              left_update;
   } result_type;

endpackage

/* rtl/csv_drive_command_parser.sv */
// Top level of the drive command line parser.
//
// Input stream (req_*): one received ASCII byte per transaction. Only digits,
// '-' and ',' are kept; CR or LF closes the line; everything else is dropped,
// as are kept bytes past LINE_CAPACITY-1 on one line.
// Output stream (rsp_*): one transaction per complete line (four tokens).
// Speeds are reported as their low 8 bits with an update flag when changed;
// the signal command (off / left / right) is reported when either flag token
// changed. A field whose update flag is clear reads as zero.
// Throughput: one byte per cycle while the queue is not full. The front classifies the byte in
// the cycle it is accepted and writes a 4-entry queue; the back pops one entry
// per cycle unless stalled at a line end, doing one multiply-by-ten-and-add step per digit.
// With the queue empty, an accepted CR/LF transaction is first written into
// the queue and then loaded into the output register, which raises
// rsp_tvalid.
// When rsp_tready is low, the result holds in the output register; the back
// keeps consuming digits and commas and stalls only at the next line end.
// req_tready drops only if that stall fills the queue.
// Reset clears the line state and the previous-line values to zero, empties
// the queue and drops any pending result.
module csv_drive_command_parser #(
   parameter int LINE_CAPACITY = 64,
   parameter int VALUE_WIDTH   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [0] left_update, [8:1] left_speed,
                                    // [9] right_update, [17:10] right_speed,
                                    // [18] signal_update, [20:19] signal_command,
                                    // [23:21] zero
);

   csvdcp_pkg::entry_type push_entry, head_entry;
   logic push, q_full, head_valid, pop;

   // front: byte classification and line length limit
   csvdcp_front #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouples front from a stalled back
   csvdcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // back: tokens, numbers, change detection, output register
   csvdcp_back #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (head_valid),
      .q_entry    (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* rtl/csvdcp_front.sv */
// Front end: classifies received bytes, enforces line capacity, pushes kept bytes.
module csvdcp_front #(
   parameter int LINE_CAPACITY = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   input  logic                      q_full,
   output logic                      push,
   output csvdcp_pkg::entry_type     push_entry
);

   localparam int KEPT_W = $clog2(LINE_CAPACITY);

   logic [KEPT_W-1:0] kept_ff, kept_in;
   logic is_digit, is_eol, is_keep, room, accept;

   always_comb begin
      is_digit   = (req_tdata >= csvdcp_pkg::CHAR_ZERO) && (req_tdata <= csvdcp_pkg::CHAR_NINE);
      is_eol     = (req_tdata == csvdcp_pkg::CHAR_CR) || (req_tdata == csvdcp_pkg::CHAR_LF);
      is_keep    = is_digit || (req_tdata == csvdcp_pkg::CHAR_MINUS) ||
                   (req_tdata == csvdcp_pkg::CHAR_COMMA);
      room       = (kept_ff != KEPT_W'(LINE_CAPACITY - 1));
      req_tready = !q_full;
      accept     = req_tvalid && req_tready;
      push       = accept && (is_eol || (is_keep && room));

      push_entry.digit    = req_tdata[3:0];
      push_entry.nonempty = (kept_ff != '0);
      if (is_eol) begin
         push_entry.kind = csvdcp_pkg::KIND_EOL;
      end else if (is_digit) begin
         push_entry.kind = csvdcp_pkg::KIND_DIGIT;
      end else if (req_tdata == csvdcp_pkg::CHAR_MINUS) begin
         push_entry.kind = csvdcp_pkg::KIND_MINUS;
      end else begin
         push_entry.kind = csvdcp_pkg::KIND_COMMA;
      end

      kept_in = kept_ff;
      if (accept && is_eol) begin
         kept_in = '0;
      end else if (accept && is_keep && room) begin
         kept_in = kept_ff + KEPT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff <= '0;
      end else begin
         kept_ff <= kept_in;
      end
   end

endmodule

/* rtl/csvdcp_queue.sv */
// Short FIFO of classified bytes between front and back.
module csvdcp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  csvdcp_pkg::entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output csvdcp_pkg::entry_type head_entry
);

   csvdcp_pkg::entry_type                   mem_ff [csvdcp_pkg::QUEUE_DEPTH];
   logic [csvdcp_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [csvdcp_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;
   logic                                    do_push, do_pop;

   always_comb begin
      full       = (count_ff == csvdcp_pkg::QUEUE_CNT_W'(csvdcp_pkg::QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_entry = mem_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + csvdcp_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + csvdcp_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + csvdcp_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - csvdcp_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/csvdcp_back.sv */
// Back end: token splitting, number reading, change detection, result register.
module csvdcp_back #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   input  csvdcp_pkg::entry_type                 q_entry,
   output logic                                  pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [csvdcp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);

   localparam int VW = VALUE_WIDTH;
   localparam logic [1:0] PHASE_START  = 2'd0;
   localparam logic [1:0] PHASE_SIGN   = 2'd1;
   localparam logic [1:0] PHASE_DIGITS = 2'd2;
   localparam logic [1:0] PHASE_DONE   = 2'd3;
   localparam int PAD_W = csvdcp_pkg::RSP_DATA_WIDTH - $bits(csvdcp_pkg::result_type);

   logic [1:0]    tok_ff, tok_in;
   logic          inside_ff, inside_in;
   logic [1:0]    phase_ff, phase_in;
   logic          neg_ff, neg_in;
   logic [VW-1:0] acc_ff, acc_in;
   logic [VW-1:0] tval_ff [3];
   logic [VW-1:0] tval_in [3];
   logic [VW-1:0] prev_ff [4];
   logic [VW-1:0] prev_in [4];
   logic          rsp_valid_ff, rsp_valid_in;
   csvdcp_pkg::result_type rsp_data_ff, rsp_data_in;

   logic [VW-1:0] cur_value, base_acc, acc_x10;
   logic [1:0]    base_phase;
   logic          is_digit, busy_out, lu, ru, su;

   always_comb begin
      busy_out   = rsp_valid_ff && !rsp_tready;
      pop        = q_valid && !((q_entry.kind == csvdcp_pkg::KIND_EOL) && busy_out);
      cur_value  = neg_ff ? (VW'(0) - acc_ff) : acc_ff;
      // a byte outside a token starts a fresh one
      base_phase = inside_ff ? phase_ff : PHASE_START;
      base_acc   = inside_ff ? acc_ff : '0;
      acc_x10    = (base_acc << 3) + (base_acc << 1) + VW'(q_entry.digit);
      is_digit   = (q_entry.kind == csvdcp_pkg::KIND_DIGIT);

      tok_in       = tok_ff;
      inside_in    = inside_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      tval_in      = tval_ff;
      prev_in      = prev_ff;
      rsp_valid_in = busy_out;
      rsp_data_in  = rsp_data_ff;

      lu = (tval_ff[0] != prev_ff[0]);
      ru = (tval_ff[1] != prev_ff[1]);
      su = (tval_ff[2] != prev_ff[2]) || (cur_value != prev_ff[3]);

      if (pop) begin
         if (q_entry.kind == csvdcp_pkg::KIND_EOL) begin
            if (q_entry.nonempty && (tok_ff == 2'd3) && inside_ff) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.left_update    = lu;
               rsp_data_in.left_speed     = lu ? tval_ff[0][7:0] : 8'h00;
               rsp_data_in.right_update   = ru;
               rsp_data_in.right_speed    = ru ? tval_ff[1][7:0] : 8'h00;
               rsp_data_in.signal_update  = su;
               if (!su) begin
                  rsp_data_in.signal_command = 2'd0;
               end else if (tval_ff[2] == VW'(1)) begin
                  rsp_data_in.signal_command = 2'd1;
               end else if (cur_value == VW'(1)) begin
                  rsp_data_in.signal_command = 2'd2;
               end else begin
                  rsp_data_in.signal_command = 2'd0;
               end
               prev_in[0] = tval_ff[0];
               prev_in[1] = tval_ff[1];
               prev_in[2] = tval_ff[2];
               prev_in[3] = cur_value;
            end
            tok_in    = '0;
            inside_in = 1'b0;
            phase_in  = PHASE_START;
            neg_in    = 1'b0;
            acc_in    = '0;
         end else if ((q_entry.kind == csvdcp_pkg::KIND_COMMA) && (tok_ff != 2'd3)) begin
            // comma ends one of the first three tokens; empty ones are skipped
            if (inside_ff) begin
               case (tok_ff)
                  2'd0:    tval_in[0] = cur_value;
                  2'd1:    tval_in[1] = cur_value;
                  2'd2:    tval_in[2] = cur_value;
                  default: tval_in[0] = tval_ff[0];
               endcase
               tok_in    = tok_ff + 2'd1;
               inside_in = 1'b0;
            end
         end else begin
            inside_in = 1'b1;
            neg_in    = inside_ff && neg_ff;
            acc_in    = base_acc;
            phase_in  = base_phase;
            unique case (base_phase)
               PHASE_START: begin
                  if (q_entry.kind == csvdcp_pkg::KIND_MINUS) begin
                     neg_in   = 1'b1;
                     phase_in = PHASE_SIGN;
                  end else if (is_digit) begin
                     acc_in   = VW'(q_entry.digit);
                     phase_in = PHASE_DIGITS;
                  end else begin
                     phase_in = PHASE_DONE;
                  end
               end
               PHASE_SIGN: begin
                  if (is_digit) begin
                     acc_in   = VW'(q_entry.digit);
                     phase_in = PHASE_DIGITS;
                  end else begin
                     phase_in = PHASE_DONE;
                  end
               end
               PHASE_DIGITS: begin
                  if (is_digit) begin
                     acc_in = acc_x10;
                  end else begin
                     phase_in = PHASE_DONE;
                  end
               end
               default: phase_in = PHASE_DONE;
            endcase
         end
      end

      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = {{PAD_W{1'b0}}, rsp_data_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff       <= '0;
         inside_ff    <= 1'b0;
         phase_ff     <= PHASE_START;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         tval_ff      <= '{default: '0};
         prev_ff      <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         tok_ff       <= tok_in;
         inside_ff    <= inside_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         tval_ff      <= tval_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/csvdcp_checker.sv */
// Port-level checks of the drive command line parser, bound to the top level.
module csvdcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // reset leaves nothing pending and the queue empty
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pending result or stalled input after reset");

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // fields whose update flag is clear read as zero; padding is zero; signal command is never 3
   a_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:21] == 3'b000 && rsp_tdata[20:19] != 2'b11 &&
                     (rsp_tdata[0] || rsp_tdata[8:1] == 8'h00) &&
                     (rsp_tdata[9] || rsp_tdata[17:10] == 8'h00) &&
                     (rsp_tdata[18] || rsp_tdata[20:19] == 2'b00))
      else $error("malformed result fields");

   // a new result needs a line end accepted earlier, so none right after reset
   a_no_early_result: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result without input after reset");

   logic unused_ok;
   assign unused_ok = req_tvalid ^ (^req_tdata);

endmodule

bind csv_drive_command_parser csvdcp_checker u_checker (.*);
